### rtl/mte_pkg.sv
// Shared types and constants for the MIDI track event encoder.
// No dependencies; imported by every module of the block except mte_fifo.
`default_nettype none

package mte_pkg;

	// Most bytes a single event can produce: 4 delta, 1 status, 2 data
	localparam int unsigned MaxBytes = 7;

	// End-of-track meta event bytes
	localparam logic [7:0] MetaStatus = 8'hFF;
	localparam logic [7:0] MetaEndOfTrack = 8'h2F;
	localparam logic [7:0] MetaLength = 8'h00;

	// Status high-nibble codes that matter for message length
	localparam logic [3:0] NibProgChange = 4'hC;
	localparam logic [3:0] NibChanPress = 4'hD;
	localparam logic [3:0] NibSystem = 4'hF;

	// VLQ continuation flag
	localparam logic VlqMore = 1'b1;

	// Pre-built event: bytes in emission order, count and oversize flag
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [2:0] nbytes;
		logic big;
	} mte_desc_t;

endpackage

`default_nettype wire

### rtl/midi_track_event_encoder.sv
// Timing: an accepted transaction is written to the event queue; its first byte
// then passes through the output register. Throughput: one byte per cycle while
// byte_ready holds; an event is 2 to 7 bytes; a dropped status yields no bytes.
// The input stays open while the QUEUE_DEPTH-entry event queue has room.
// Reset (arst_n low, asynchronous): tick, running status and byte count clear.
// Depends on mte_pkg, mte_front, mte_fifo, mte_back.
`default_nettype none

module midi_track_event_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_ready,
	input  wire logic        req_type,
	input  wire logic [7:0]  status,
	input  wire logic [7:0]  data_first,
	input  wire logic [7:0]  data_second,
	input  wire logic [31:0] event_tick,
	output logic             byte_valid,
	input  wire logic        byte_ready,
	output logic [7:0]       out_byte,
	output logic             last_byte,
	output logic [31:0]      track_bytes,
	output logic             delta_too_big
);

	import mte_pkg::*;

	logic push, pop, full, head_valid;
	mte_desc_t push_desc, head_desc;

	assign msg_ready = !full;

	mte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (msg_valid && msg_ready),
		.req_type   (req_type),
		.status     (status),
		.data_first (data_first),
		.data_second(data_second),
		.event_tick (event_tick),
		.push       (push),
		.push_desc  (push_desc)
	);

	mte_fifo #(
		.WIDTH($bits(mte_desc_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_desc),
		.full     (full),
		.pop      (pop),
		.head_data(head_desc),
		.nonempty (head_valid)
	);

	mte_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.track_bytes  (track_bytes),
		.delta_too_big(delta_too_big)
	);

`ifndef NO_ASSERTIONS
	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("event queue overflow");

	// a byte that does not end its event is followed at once by the next one
	a_event_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready && !last_byte |=> byte_valid)
		else $error("event bytes not contiguous");

	// consecutive output bytes carry consecutive track counts
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready |=> !byte_valid || (track_bytes == $past(track_bytes) + 32'd1))
		else $error("track byte count skipped");

	// queue only drains an entry that exists
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### rtl/mte_fifo.sv
// Small register queue between the event classifier and the byte serializer.
// Generic in width and depth; head entry is visible without popping.
`default_nettype none

module mte_fifo #(
	parameter int unsigned WIDTH = 60,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head_data,
	output logic                  nonempty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/mte_front.sv
// Front end: accepts timed messages, drops unsupported statuses, computes the
// tick delta and running status, and builds the byte list. Uses mte_pkg.
`default_nettype none

module mte_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       req_type,
	input  wire logic [7:0] status,
	input  wire logic [7:0] data_first,
	input  wire logic [7:0] data_second,
	input  wire logic [31:0] event_tick,
	output logic            push,
	output mte_pkg::mte_desc_t push_desc
);

	import mte_pkg::*;

	logic [31:0] last_tick_q;
	logic [7:0] running_status_q;

	logic [7:0] st, d1, d2;
	logic keep, three;
	logic [31:0] delta;
	logic [3:0][6:0] grp;
	logic [2:0] nv;
	logic [2:0] pos;
	logic [MaxBytes-1:0][7:0] buf_b;

	// classify the request
	always_comb begin
		if (req_type) begin
			st = MetaStatus;
			d1 = MetaEndOfTrack;
			d2 = MetaLength;
			keep = 1'b1;
			three = 1'b1;
		end else begin
			st = status;
			d1 = data_first;
			d2 = data_second;
			keep = status[7] && (status[7:4] != NibSystem);
			three = (status[7:4] != NibProgChange) && (status[7:4] != NibChanPress);
		end
	end

	// tick delta split into 7-bit groups, most significant in grp[3]
	assign delta = event_tick - last_tick_q;
	assign grp = delta[27:0];

	always_comb begin
		priority if (|delta[27:21]) nv = 3'd4;
		else if (|delta[20:14]) nv = 3'd3;
		else if (|delta[13:7]) nv = 3'd2;
		else nv = 3'd1;
	end

	// assemble bytes in emission order
	always_comb begin
		buf_b = '0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < nv) begin
				buf_b[i] = {(3'(i) != nv - 3'd1) ? VlqMore : ~VlqMore,
					grp[2'(nv - 3'd1 - 3'(i))]};
			end
		end
		pos = nv;
		if (st != running_status_q) begin
			buf_b[pos] = st;
			pos = pos + 3'd1;
		end
		buf_b[pos] = d1;
		pos = pos + 3'd1;
		if (three) begin
			buf_b[pos] = d2;
			pos = pos + 3'd1;
		end
	end

	assign push = accept && keep;
	assign push_desc.bytes = buf_b;
	assign push_desc.nbytes = pos;
	assign push_desc.big = |delta[31:28];

	// encoder state follows every kept transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= '0;
			running_status_q <= '0;
		end else if (push) begin
			last_tick_q <= event_tick;
			running_status_q <= st;
		end
	end

endmodule

`default_nettype wire

### rtl/mte_back.sv
// Back end: walks the queued event into the output register one byte per cycle
// while that register is free, and keeps the track byte count. Uses mte_pkg.
`default_nettype none

module mte_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       head_valid,
	input  wire mte_pkg::mte_desc_t head_desc,
	output logic            pop,
	output logic            byte_valid,
	input  wire logic       byte_ready,
	output logic [7:0]      out_byte,
	output logic            last_byte,
	output logic [31:0]     track_bytes,
	output logic            delta_too_big
);

	import mte_pkg::*;

	logic [2:0] idx_q;
	logic byte_valid_q;
	logic [31:0] count_q;
	logic [7:0] byte_q;
	logic last_q;
	logic big_q;
	logic load;
	logic at_last;

	// output register is free when empty or being taken
	assign load = !byte_valid_q || byte_ready;
	assign at_last = (idx_q == head_desc.nbytes - 3'd1);
	assign pop = load && head_valid && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			byte_valid_q <= 1'b0;
			count_q <= '0;
		end else if (load) begin
			byte_valid_q <= head_valid;
			if (head_valid) begin
				count_q <= count_q + 32'd1;
				idx_q <= at_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	// payload of the output register
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			byte_q <= head_desc.bytes[idx_q];
			last_q <= at_last;
			big_q <= head_desc.big;
		end
	end

	assign byte_valid = byte_valid_q;
	assign out_byte = byte_q;
	assign last_byte = last_q;
	assign track_bytes = count_q;
	assign delta_too_big = big_q;

endmodule

`default_nettype wire
